>>> hdl/cpioh_pkg.sv
`default_nettype none

package cpioh_pkg;

  localparam int unsigned HEADER_BYTES = 110;
  localparam int unsigned MAGIC_BYTES  = 6;
  localparam int unsigned TRAILER_MAX  = 16;

  localparam logic [6:0] OFF_LAST_HDR = 7'd109;
  localparam logic [6:0] OFF_NAME     = 7'd110;
  localparam logic [6:0] OFF_MAGIC    = 7'd6;
  localparam logic [6:0] OFF_FSIZE    = 7'd54;
  localparam logic [6:0] OFF_NSIZE    = 7'd94;
  localparam logic [6:0] HEX_CHARS    = 7'd8;
  localparam logic [6:0] OFF_NAME_LEN = 7'd1;
  localparam logic [6:0] OFF_NEND     = 7'd102;
  localparam logic [6:0] OFF_DATA     = 7'd103;
  localparam logic [6:0] OFF_DEND     = 7'd104;
  localparam logic [6:0] OFF_NEXT     = 7'd105;

  localparam logic [7:0] MAGIC [MAGIC_BYTES] = '{8'h30, 8'h37, 8'h30, 8'h37, 8'h30, 8'h31};

  localparam logic [7:0] TRAILER [TRAILER_MAX] = '{
    8'h54, 8'h52, 8'h41, 8'h49, 8'h4c, 8'h45, 8'h52, 8'h21,
    8'h21, 8'h21, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef enum logic [1:0] {
    ST_PARSED  = 2'd0,
    ST_END     = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] name_addr;
    logic [31:0] name_length;
    logic [31:0] file_size;
    logic [31:0] data_addr;
    logic [31:0] next_addr;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nibble;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    d.ok = 1'b1;
    d.nibble = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.nibble = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d.nibble = 4'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d.nibble = 4'(c - 8'h41 + 8'd10);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

>>> hdl/cpio_entry_header_parser_unit.sv
`default_nettype none

// channel  direction  handshake              payload
// in       input      in_valid / in_stall    data_byte, entry_start, entry_addr
// out      output     out_valid / out_stall  status, name_addr, name_length, file_size,
//                                            data_addr, next_addr
//
// one archive byte per cycle while in_stall is low; a result is registered from
// the byte that ends the entry (last header byte or the byte that ends the name compare)
// address sums are spread over header bytes 1 and 102..105, one add stage per byte
// rst clears the byte counter and leaves the block waiting for an entry start
// in_stall rises only while the output register and its skid stage both hold results

module cpio_entry_header_parser_unit #(
  parameter int ADDR_WIDTH  = 32,
  parameter int ALIGN_BYTES = 4,
  parameter int TRAILER_LEN = 10
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire  [7:0]                data_byte,
  input  wire                       entry_start,
  input  wire  [31:0]               entry_addr,
  output logic                      out_valid,
  input  wire                       out_stall,
  output cpioh_pkg::status_t        status,
  output logic [31:0]               name_addr,
  output logic [31:0]               name_length,
  output logic [31:0]               file_size,
  output logic [31:0]               data_addr,
  output logic [31:0]               next_addr
);

  localparam int AW = ADDR_WIDTH;
  localparam int RW = $clog2(ALIGN_BYTES + 1);
  localparam int IW = $clog2(ADDR_WIDTH);
  localparam logic [RW+3:0] A_HEX = (RW+4)'(ALIGN_BYTES);
  localparam logic [RW:0]   A_BIT = (RW+1)'(ALIGN_BYTES);
  localparam logic [RW+1:0] A_SUM = (RW+2)'(ALIGN_BYTES);
  localparam logic [RW-1:0] A_RES = RW'(ALIGN_BYTES);
  localparam logic [RW-1:0] H_RES = RW'(cpioh_pkg::HEADER_BYTES % ALIGN_BYTES);
  localparam logic [AW-1:0] ALIGN_M1 = AW'(ALIGN_BYTES - 1);
  localparam logic [AW-1:0] HDR_LEN  = AW'(cpioh_pkg::HEADER_BYTES);
  localparam logic [6:0]    AW_OFF   = 7'(ADDR_WIDTH);
  localparam logic [31:0]   TL_WIDE  = 32'(TRAILER_LEN);
  localparam logic [3:0]    TL_CNT   = 4'(TRAILER_LEN);

  function automatic logic [RW-1:0] hex_res(input logic [RW-1:0] r, input logic [3:0] v);
    logic [RW+3:0] t;
    t = {r, v};
    for (int s = 3; s >= 0; s--) begin
      if (t >= (A_HEX << s)) begin
        t = t - (A_HEX << s);
      end
    end
    return t[RW-1:0];
  endfunction

  function automatic logic [RW-1:0] bit_res(input logic [RW-1:0] r, input logic b);
    logic [RW:0] t;
    t = {r, b};
    if (t >= A_BIT) begin
      t = t - A_BIT;
    end
    return t[RW-1:0];
  endfunction

  function automatic logic [AW-1:0] pad_of(input logic [RW-1:0] r);
    logic [RW-1:0] p;
    p = (r == '0) ? '0 : A_RES - r;
    return {{(AW-RW){1'b0}}, p};
  endfunction

  function automatic logic [AW-1:0] to_addr(input logic [31:0] x);
    logic [AW+31:0] t;
    t = {{AW{1'b0}}, x};
    return t[AW-1:0];
  endfunction

  function automatic logic [31:0] to_out(input logic [AW-1:0] a);
    logic [AW+31:0] t;
    t = {32'd0, a};
    return t[31:0];
  endfunction

  logic [6:0]    byte_offset, byte_offset_next;
  logic          entry_done, entry_done_next;
  logic [AW-1:0] base, base_next;
  logic [AW-1:0] name_a, name_a_next;
  logic          name_wrap, name_wrap_next;
  logic [31:0]   size_accum, size_accum_next;
  logic [31:0]   ns_accum, ns_accum_next;
  logic          hex_stopped, hex_stopped_next;
  logic          name_matches, name_matches_next;
  logic [3:0]    compare_count, compare_count_next;
  logic [RW-1:0] res_base, res_base_next;
  logic [RW-1:0] res_size, res_size_next;
  logic [RW-1:0] res_ns, res_ns_next;
  logic [RW-1:0] res_nend, res_nend_next;
  logic [AW-1:0] nend, nend_next;
  logic          nend_wrap, nend_wrap_next;
  logic [AW-1:0] data_a, data_a_next;
  logic          data_wrap, data_wrap_next;
  logic [AW-1:0] dend, dend_next;
  logic          dend_wrap, dend_wrap_next;
  logic [AW-1:0] next_a, next_a_next;
  logic          next_wrap, next_wrap_next;

  logic               accept;
  logic               res_valid;
  cpioh_pkg::result_t res;
  cpioh_pkg::result_t out_data;

  logic [6:0]            off;
  logic [6:0]            bidx;
  logic [AW:0]           sum_a;
  logic [AW:0]           sum_b;
  logic [RW+1:0]         rsum;
  logic [3:0]            klen;
  logic [3:0]            cc_inc;
  cpioh_pkg::hex_digit_t hd;

  assign accept = in_valid && !in_stall;

  always_comb begin
    byte_offset_next   = byte_offset;
    entry_done_next    = entry_done;
    base_next          = base;
    name_a_next        = name_a;
    name_wrap_next     = name_wrap;
    size_accum_next    = size_accum;
    ns_accum_next      = ns_accum;
    hex_stopped_next   = hex_stopped;
    name_matches_next  = name_matches;
    compare_count_next = compare_count;
    res_base_next      = res_base;
    res_size_next      = res_size;
    res_ns_next        = res_ns;
    res_nend_next      = res_nend;
    nend_next          = nend;
    nend_wrap_next     = nend_wrap;
    data_a_next        = data_a;
    data_wrap_next     = data_wrap;
    dend_next          = dend;
    dend_wrap_next     = dend_wrap;
    next_a_next        = next_a;
    next_wrap_next     = next_wrap;
    res_valid          = 1'b0;
    res                = '0;
    off                = entry_start ? 7'd0 : byte_offset;
    bidx               = AW_OFF - byte_offset;
    sum_a              = '0;
    sum_b              = '0;
    rsum               = '0;
    klen               = (ns_accum < TL_WIDE) ? ns_accum[3:0] : TL_CNT;
    cc_inc             = compare_count + 4'd1;
    hd                 = cpioh_pkg::hex_decode(data_byte);

    if (accept && (entry_start || !entry_done)) begin
      if (entry_start) begin
        entry_done_next    = 1'b0;
        base_next          = to_addr(entry_addr);
        size_accum_next    = '0;
        ns_accum_next      = '0;
        hex_stopped_next   = 1'b0;
        name_matches_next  = 1'b1;
        compare_count_next = '0;
        res_base_next      = '0;
        res_size_next      = '0;
        res_ns_next        = '0;
      end

      if (off < cpioh_pkg::OFF_NAME) begin
        if (off < cpioh_pkg::OFF_MAGIC && data_byte != cpioh_pkg::MAGIC[off[2:0]]) begin
          name_matches_next = 1'b0;
        end
        if (off == cpioh_pkg::OFF_FSIZE || off == cpioh_pkg::OFF_NSIZE) begin
          hex_stopped_next = 1'b0;
        end
        if (off >= cpioh_pkg::OFF_FSIZE && off < cpioh_pkg::OFF_FSIZE + cpioh_pkg::HEX_CHARS
            && !hex_stopped_next) begin
          if (hd.ok) begin
            size_accum_next = {size_accum[27:0], hd.nibble};
            res_size_next   = hex_res(res_size, hd.nibble);
          end else begin
            hex_stopped_next = 1'b1;
          end
        end
        if (off >= cpioh_pkg::OFF_NSIZE && off < cpioh_pkg::OFF_NSIZE + cpioh_pkg::HEX_CHARS
            && !hex_stopped_next) begin
          if (hd.ok) begin
            ns_accum_next = {ns_accum[27:0], hd.nibble};
            res_ns_next   = hex_res(res_ns, hd.nibble);
          end else begin
            hex_stopped_next = 1'b1;
          end
        end

        // address pipeline, one add stage on each of header bytes 1 and 102..105
        if (off == cpioh_pkg::OFF_NAME_LEN) begin
          sum_a          = {1'b0, base} + {1'b0, HDR_LEN};
          name_a_next    = sum_a[AW-1:0];
          name_wrap_next = sum_a[AW];
        end
        if (off >= 7'd1 && off <= AW_OFF) begin
          res_base_next = bit_res(res_base, base[bidx[IW-1:0]]);
        end
        if (off == cpioh_pkg::OFF_NEND) begin
          sum_a          = {1'b0, name_a} + {1'b0, to_addr(ns_accum)};
          nend_next      = sum_a[AW-1:0];
          nend_wrap_next = sum_a[AW];
          rsum           = {2'b0, res_base} + {2'b0, H_RES} + {2'b0, res_ns};
          if (rsum >= (A_SUM << 1)) begin
            rsum = rsum - (A_SUM << 1);
          end else if (rsum >= A_SUM) begin
            rsum = rsum - A_SUM;
          end
          res_nend_next = rsum[RW-1:0];
        end
        if (off == cpioh_pkg::OFF_DATA) begin
          sum_a          = {1'b0, nend} + {1'b0, ALIGN_M1};
          sum_b          = {1'b0, nend} + {1'b0, pad_of(res_nend)};
          data_wrap_next = sum_a[AW];
          data_a_next    = sum_b[AW-1:0];
        end
        if (off == cpioh_pkg::OFF_DEND) begin
          sum_a          = {1'b0, data_a} + {1'b0, to_addr(size_accum)};
          dend_next      = sum_a[AW-1:0];
          dend_wrap_next = sum_a[AW];
        end
        if (off == cpioh_pkg::OFF_NEXT) begin
          sum_a          = {1'b0, dend} + {1'b0, ALIGN_M1};
          sum_b          = {1'b0, dend} + {1'b0, pad_of(res_size)};
          next_wrap_next = sum_a[AW];
          next_a_next    = sum_b[AW-1:0];
        end

        if (off < cpioh_pkg::OFF_LAST_HDR) begin
          byte_offset_next = off + 7'd1;
        end else if (base == '0 || !name_matches_next || name_wrap || nend_wrap) begin
          res_valid       = 1'b1;
          res.status      = cpioh_pkg::ST_INVALID;
          entry_done_next = 1'b1;
        end else begin
          name_matches_next  = 1'b1;
          compare_count_next = '0;
          if (ns_accum == '0) begin
            res_valid       = 1'b1;
            res.status      = cpioh_pkg::ST_END;
            entry_done_next = 1'b1;
          end else begin
            byte_offset_next = cpioh_pkg::OFF_NAME;
          end
        end
      end else begin
        if (data_byte != cpioh_pkg::TRAILER[compare_count]) begin
          name_matches_next = 1'b0;
          res_valid         = 1'b1;
          entry_done_next   = 1'b1;
          if (data_wrap || dend_wrap || next_wrap) begin
            res.status = cpioh_pkg::ST_INVALID;
          end else begin
            res.status      = cpioh_pkg::ST_PARSED;
            res.name_addr   = to_out(name_a);
            res.name_length = ns_accum;
            res.file_size   = size_accum;
            res.data_addr   = to_out(data_a);
            res.next_addr   = to_out(next_a);
          end
        end else if (data_byte == 8'd0 || cc_inc >= klen) begin
          compare_count_next = cc_inc;
          res_valid          = 1'b1;
          res.status         = cpioh_pkg::ST_END;
          entry_done_next    = 1'b1;
        end else begin
          compare_count_next = cc_inc;
          byte_offset_next   = off + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
      entry_done  <= 1'b1;
    end else begin
      byte_offset <= byte_offset_next;
      entry_done  <= entry_done_next;
    end
    base          <= base_next;
    name_a        <= name_a_next;
    name_wrap     <= name_wrap_next;
    size_accum    <= size_accum_next;
    ns_accum      <= ns_accum_next;
    hex_stopped   <= hex_stopped_next;
    name_matches  <= name_matches_next;
    compare_count <= compare_count_next;
    res_base      <= res_base_next;
    res_size      <= res_size_next;
    res_ns        <= res_ns_next;
    res_nend      <= res_nend_next;
    nend          <= nend_next;
    nend_wrap     <= nend_wrap_next;
    data_a        <= data_a_next;
    data_wrap     <= data_wrap_next;
    dend          <= dend_next;
    dend_wrap     <= dend_wrap_next;
    next_a        <= next_a_next;
    next_wrap     <= next_wrap_next;
  end

  cpioh_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign status      = out_data.status;
  assign name_addr   = out_data.name_addr;
  assign name_length = out_data.name_length;
  assign file_size   = out_data.file_size;
  assign data_addr   = out_data.data_addr;
  assign next_addr   = out_data.next_addr;

endmodule

`default_nettype wire

>>> hdl/cpioh_out_skid.sv
`default_nettype none

module cpioh_out_skid (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  cpioh_pkg::result_t  push_data,
  output logic                full,
  output logic                out_valid,
  input  wire                 out_stall,
  output cpioh_pkg::result_t  out_data
);

  logic               skid_valid;
  cpioh_pkg::result_t skid_data;
  logic               pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
        out_data  <= push_data;
      end
    end else if (!out_valid) begin
      out_valid <= push;
      out_data  <= push_data;
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_data  <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> sim/tb_cpio_entry_header_parser_unit.sv
`default_nettype none

module tb_cpio_entry_header_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import cpioh_pkg::*;

  localparam int HDR_LEN      = cpioh_pkg::HEADER_BYTES;
  localparam int FS_POS       = 54;
  localparam int NS_POS       = 94;
  localparam int HEX_CHARS    = 8;
  localparam int TRAILER_CMP  = 10;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 1000000;

  localparam logic [8*6-1:0]  MAGIC_TXT   = "070701";
  localparam logic [8*10-1:0] TRAILER_TXT = "TRAILER!!!";

  typedef struct packed {
    logic [7:0]  data;
    logic        start;
    logic [31:0] addr;
  } arc_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        entry_start = 1'b0;
  logic [31:0] entry_addr = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  status_t     status;
  logic [31:0] name_addr, name_length, file_size, data_addr, next_addr;

  arc_byte_t   byte_stream_q[$];
  result_t     entry_results_q[$];
  arc_byte_t   cur_in;
  logic [7:0]  hdr[HDR_LEN];
  logic [7:0]  name_bytes[$];

  int          errors = 0;
  int          cycles = 0;
  int          items = 0;
  int          tx_gap = 0;
  int          rx_gap = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;

  // parser state
  logic [6:0]  p_off = 7'd0;
  bit          p_done = 1'b1;
  logic [31:0] p_base = 32'd0;
  logic [31:0] p_fsize = 32'd0;
  logic [31:0] p_nsize = 32'd0;
  bit          p_hexstop = 1'b0;
  bit          p_match = 1'b1;
  logic [3:0]  p_cnt = 4'd0;

  cpio_entry_header_parser_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .entry_start (entry_start),
    .entry_addr  (entry_addr),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .name_addr   (name_addr),
    .name_length (name_length),
    .file_size   (file_size),
    .data_addr   (data_addr),
    .next_addr   (next_addr)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] magic_char(input int i);
    return MAGIC_TXT[8*(5-i) +: 8];
  endfunction

  function automatic logic [7:0] trailer_char(input int i);
    if (i < TRAILER_CMP) begin
      return TRAILER_TXT[8*(TRAILER_CMP-1-i) +: 8];
    end
    return 8'h00;
  endfunction

  function automatic bit is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    if (c <= 8'h39) begin
      return 4'(c - 8'h30);
    end else if (c >= 8'h61) begin
      return 4'(c - 8'h57);
    end
    return 4'(c - 8'h37);
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 2);
    end else if (r < 97) begin
      return $urandom_range(3, 8);
    end
    return $urandom_range(15, 30);
  endfunction

  task automatic report_entry(input status_t st, input logic [31:0] na, input logic [31:0] nl,
                              input logic [31:0] fs, input logic [31:0] da,
                              input logic [31:0] nx);
    result_t res;
    res.status      = st;
    res.name_addr   = na;
    res.name_length = nl;
    res.file_size   = fs;
    res.data_addr   = da;
    res.next_addr   = nx;
    entry_results_q.push_back(res);
    p_done = 1'b1;
  endtask

  // name compare failed: lay out data and next entry, any wrap is invalid
  task automatic finish_entry();
    logic [31:0] name, nend, data, dend;
    logic [32:0] t;
    name = p_base + 32'(HDR_LEN);
    nend = name + p_nsize;
    t = {1'b0, nend} + 33'd3;
    if (t[32]) begin
      report_entry(ST_INVALID, 0, 0, 0, 0, 0);
      return;
    end
    data = t[31:0] & ~32'h3;
    t = {1'b0, data} + {1'b0, p_fsize};
    if (t[32]) begin
      report_entry(ST_INVALID, 0, 0, 0, 0, 0);
      return;
    end
    dend = t[31:0];
    t = {1'b0, dend} + 33'd3;
    if (t[32]) begin
      report_entry(ST_INVALID, 0, 0, 0, 0, 0);
      return;
    end
    report_entry(ST_PARSED, name, p_nsize, p_fsize, data, t[31:0] & ~32'h3);
  endtask

  task automatic parse_byte(input arc_byte_t it);
    logic [6:0]  off;
    logic [32:0] name_s, nend_s;
    logic [3:0]  k;
    if (it.start) begin
      p_off     = 7'd0;
      p_done    = 1'b0;
      p_base    = it.addr;
      p_fsize   = 32'd0;
      p_nsize   = 32'd0;
      p_hexstop = 1'b0;
      p_match   = 1'b1;
      p_cnt     = 4'd0;
    end else if (p_done) begin
      return;
    end
    off = p_off;
    if (off < HDR_LEN) begin
      if (off < 6 && it.data != magic_char(off)) begin
        p_match = 1'b0;
      end
      if (off == FS_POS || off == NS_POS) begin
        p_hexstop = 1'b0;
      end
      if ((off >= FS_POS && off < FS_POS + HEX_CHARS) ||
          (off >= NS_POS && off < NS_POS + HEX_CHARS)) begin
        if (!p_hexstop) begin
          if (!is_hex(it.data)) begin
            p_hexstop = 1'b1;
          end else if (off < NS_POS) begin
            p_fsize = {p_fsize[27:0], hex_val(it.data)};
          end else begin
            p_nsize = {p_nsize[27:0], hex_val(it.data)};
          end
        end
      end
      if (off < HDR_LEN - 1) begin
        p_off = off + 7'd1;
        return;
      end
      name_s = {1'b0, p_base} + 33'(HDR_LEN);
      nend_s = {1'b0, name_s[31:0]} + {1'b0, p_nsize};
      if (p_base == 0 || !p_match || name_s[32] || nend_s[32]) begin
        report_entry(ST_INVALID, 0, 0, 0, 0, 0);
        return;
      end
      p_match = 1'b1;
      p_cnt   = 4'd0;
      if (p_nsize == 0) begin
        report_entry(ST_END, 0, 0, 0, 0, 0);
        return;
      end
      p_off = off + 7'd1;
      return;
    end
    k = (p_nsize < 32'(TRAILER_CMP)) ? p_nsize[3:0] : 4'(TRAILER_CMP);
    if (it.data != trailer_char(p_cnt)) begin
      p_match = 1'b0;
      finish_entry();
      return;
    end
    if (it.data == 8'h00) begin
      report_entry(ST_END, 0, 0, 0, 0, 0);
      return;
    end
    p_cnt = p_cnt + 4'd1;
    if (p_cnt >= k) begin
      report_entry(ST_END, 0, 0, 0, 0, 0);
      return;
    end
    p_off = off + 7'd1;
  endtask

  task automatic push_byte(input logic [7:0] d, input logic s, input logic [31:0] a);
    arc_byte_t it;
    it.data  = d;
    it.start = s;
    it.addr  = a;
    byte_stream_q.push_back(it);
    items++;
  endtask

  function automatic logic [7:0] non_hex();
    logic [7:0] c;
    do begin
      c = 8'($urandom);
    end while (is_hex(c));
    return c;
  endfunction

  // hex text of v at pos; the digit at stop is non-hex, digits after it are random
  task automatic put_hex(input int pos, input logic [31:0] v, input int stop);
    logic [3:0] nib;
    logic [7:0] c;
    for (int i = 0; i < HEX_CHARS; i++) begin
      nib = v[31-4*i -: 4];
      if (nib < 4'd10) begin
        c = 8'h30 + 8'(nib);
      end else begin
        c = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
      end
      if (i == stop) begin
        c = non_hex();
      end else if (i > stop) begin
        c = 8'($urandom);
      end
      hdr[pos+i] = c;
    end
  endtask

  task automatic fill_random_name(input int len);
    name_bytes.delete();
    repeat (len) name_bytes.push_back(8'($urandom));
  endtask

  task automatic fill_trailer_name(input int len, input int bad_at);
    logic [7:0] c;
    name_bytes.delete();
    for (int i = 0; i < len; i++) begin
      c = (i < TRAILER_CMP) ? trailer_char(i) : 8'($urandom);
      if (i == bad_at) begin
        c = c ^ 8'($urandom_range(1, 255));
      end
      name_bytes.push_back(c);
    end
  endtask

  task automatic send_entry(input logic [31:0] base, input logic [31:0] fsize,
                            input logic [31:0] nsize, input int f_stop, input int n_stop,
                            input bit bad_magic, input int cut);
    int j;
    for (int i = 0; i < HDR_LEN; i++) begin
      hdr[i] = 8'($urandom);
    end
    for (int i = 0; i < 6; i++) begin
      hdr[i] = magic_char(i);
    end
    if (bad_magic) begin
      j = $urandom_range(0, 5);
      hdr[j] = hdr[j] ^ 8'($urandom_range(1, 255));
    end
    put_hex(FS_POS, fsize, f_stop);
    put_hex(NS_POS, nsize, n_stop);
    push_byte(hdr[0], 1'b1, base);
    for (int i = 1; i < cut; i++) begin
      push_byte(hdr[i], 1'b0, $urandom);
    end
    if (cut == HDR_LEN) begin
      foreach (name_bytes[i]) push_byte(name_bytes[i], 1'b0, $urandom);
    end
  endtask

  task automatic send_random_entry();
    logic [31:0] base, fsize, nsize;
    int          r, cmp, len, f_stop, n_stop, cut;
    bit          bad;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      base = 32'd0;
    end else if (r < 10) begin
      base = 32'hFFFF_FF00 | $urandom_range(0, 255);
    end else if (r < 40) begin
      base = $urandom;
    end else begin
      base = $urandom_range(1, 32'h00FF_FFFF);
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      nsize = $urandom_range(0, 24);
    end else if (r < 85) begin
      nsize = $urandom_range(0, 400);
    end else begin
      nsize = $urandom;
    end
    r = $urandom_range(0, 99);
    if (r < 15) begin
      fsize = 32'd0;
    end else if (r < 70) begin
      fsize = $urandom_range(1, 5000);
    end else begin
      fsize = $urandom;
    end
    f_stop = ($urandom_range(0, 99) < 8) ? $urandom_range(0, 7) : HEX_CHARS;
    n_stop = ($urandom_range(0, 99) < 8) ? $urandom_range(0, 7) : HEX_CHARS;
    bad = ($urandom_range(0, 99) < 5);
    cut = ($urandom_range(0, 99) < 4) ? $urandom_range(1, HDR_LEN - 1) : HDR_LEN;
    cmp = (nsize < 32'(TRAILER_CMP)) ? int'(nsize) : TRAILER_CMP;
    len = cmp + $urandom_range(0, 2);
    if (cmp > 0 && $urandom_range(0, 99) < 6) begin
      len = $urandom_range(0, cmp - 1);
    end
    if ($urandom_range(0, 99) < 45) begin
      fill_trailer_name(len, ($urandom_range(0, 99) < 35) ?
                        $urandom_range(0, (cmp > 0) ? cmp - 1 : 0) : -1);
    end else begin
      fill_random_name(len);
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0, $urandom);
    end
    send_entry(base, fsize, nsize, f_stop, n_stop, bad, cut);
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (byte_stream_q.size() != 0 || in_valid || entry_results_q.size() != 0);
  endtask

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_byte(cur_in);
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (byte_stream_q.size() != 0) begin
          cur_in = byte_stream_q.pop_front();
          in_valid    <= 1'b1;
          data_byte   <= cur_in.data;
          entry_start <= cur_in.start;
          entry_addr  <= cur_in.addr;
          tx_gap = pick_gap(tx_calm);
          if ($urandom_range(0, 99) == 0) begin
            tx_calm = !tx_calm;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    result_t exp_res;
    if (rst) begin
      out_stall <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (entry_results_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("result with no entry pending: status %0d name_addr %h next_addr %h",
                     status, name_addr, next_addr);
          end
        end else begin
          exp_res = entry_results_q.pop_front();
          if (status !== exp_res.status || name_addr !== exp_res.name_addr ||
              name_length !== exp_res.name_length || file_size !== exp_res.file_size ||
              data_addr !== exp_res.data_addr || next_addr !== exp_res.next_addr) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch exp: st %0d na %h nl %h fs %h da %h nx %h",
                       exp_res.status, exp_res.name_addr, exp_res.name_length,
                       exp_res.file_size, exp_res.data_addr, exp_res.next_addr);
              $display("         got: st %0d na %h nl %h fs %h da %h nx %h",
                       status, name_addr, name_length, file_size, data_addr, next_addr);
            end
          end
        end
      end
      if (rx_gap > 0) begin
        rx_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        rx_gap = pick_gap(rx_calm);
      end
      if ($urandom_range(0, 149) == 0) begin
        rx_calm = !rx_calm;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int entry_count;
    entry_count = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // bytes before any entry start
    repeat (3) push_byte(8'($urandom), 1'b0, $urandom);
    fill_random_name(5);
    name_bytes[0] = 8'h68;
    send_entry(32'h0000_1000, 32'h0000_1234, 32'd5, HEX_CHARS, HEX_CHARS, 1'b0, HDR_LEN);
    // trailer with its terminating zero
    fill_trailer_name(11, -1);
    name_bytes[10] = 8'h00;
    send_entry(32'h0000_2000, 32'd0, 32'd11, HEX_CHARS, HEX_CHARS, 1'b0, HDR_LEN);
    // empty name, trailing bytes ignored
    fill_random_name(4);
    send_entry(32'h0000_3000, 32'd77, 32'd0, HEX_CHARS, HEX_CHARS, 1'b0, HDR_LEN);
    fill_random_name(6);
    send_entry(32'h0000_4000, 32'd8, 32'd6, HEX_CHARS, HEX_CHARS, 1'b1, HDR_LEN);
    send_entry(32'h0000_0000, 32'd8, 32'd6, HEX_CHARS, HEX_CHARS, 1'b0, HDR_LEN);
    // address wraps: header, name end, data align, data end, next align
    send_entry(32'hFFFF_FFA0, 32'd8, 32'd6, HEX_CHARS, HEX_CHARS, 1'b0, HDR_LEN);
    send_entry(32'hFFFF_0000, 32'd8, 32'h0001_0000, HEX_CHARS, HEX_CHARS, 1'b0, HDR_LEN);
    fill_random_name(12);
    name_bytes[0] = 8'h78;
    send_entry(32'hFFFF_FF00, 32'd0, 32'h0000_008F, HEX_CHARS, HEX_CHARS, 1'b0, HDR_LEN);
    fill_random_name(4);
    name_bytes[0] = 8'h78;
    send_entry(32'h0000_0100, 32'hFFFF_FFFF, 32'd4, HEX_CHARS, HEX_CHARS, 1'b0, HDR_LEN);
    send_entry(32'h0000_0100, 32'hFFFF_FE8A, 32'd4, HEX_CHARS, HEX_CHARS, 1'b0, HDR_LEN);
    // hex decoding cut short
    fill_random_name(12);
    name_bytes[0] = 8'h78;
    send_entry(32'h0000_5000, 32'hABCD_EF01, 32'h0000_1234, 3, 5, 1'b0, HDR_LEN);
    send_entry(32'h0000_6000, 32'h00AB_CDEF, 32'h0000_0012, HEX_CHARS, 0, 1'b0, HDR_LEN);
    // short and full trailer compares, mismatch on the last compared byte
    fill_trailer_name(3, -1);
    send_entry(32'h0000_7000, 32'd1, 32'd3, HEX_CHARS, HEX_CHARS, 1'b0, HDR_LEN);
    fill_trailer_name(10, -1);
    send_entry(32'h0000_8000, 32'd2, 32'd10, HEX_CHARS, HEX_CHARS, 1'b0, HDR_LEN);
    fill_trailer_name(10, 9);
    send_entry(32'h0000_9000, 32'd3, 32'd10, HEX_CHARS, HEX_CHARS, 1'b0, HDR_LEN);
    // new entry start while header, then name, is in progress
    send_entry(32'h0000_A000, 32'd4, 32'd5, HEX_CHARS, HEX_CHARS, 1'b0, 60);
    fill_trailer_name(4, -1);
    send_entry(32'h0000_B000, 32'd5, 32'd20, HEX_CHARS, HEX_CHARS, 1'b0, HDR_LEN);
    fill_random_name(30);
    name_bytes[0] = 8'h78;
    send_entry(32'h0000_C001, 32'hABCD_EF01, 32'd30, HEX_CHARS, HEX_CHARS, 1'b0, HDR_LEN);
    wait_drained();

    items = 0;
    while (entry_count < 48 || items < 750) begin
      send_random_entry();
      entry_count++;
      if (entry_count == 24) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && entry_results_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
